/* rtl/ned_pkg.sv */
`timescale 1ns / 1ps

package ned_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    // Effective width plus one and the pending count reach MAX_WIDTH + 1
    localparam int EW        = $clog2(MAX_WIDTH + 2);

    // Register field widths
    localparam int WIDTH_W   = 12;
    localparam int HEIGHT_W  = 16;
    localparam int THR_W     = 10;
    localparam int THR_SQ_W  = 2 * THR_W;

    localparam int CH_W      = 8;
    localparam int SUM_W     = 2 * CH_W + 2;
    localparam int MIN_COUNT = 3;
    localparam int NBR       = 8;
    localparam int CNT_W     = $clog2(NBR + 1);

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET     = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = 16'd480;
    localparam logic [THR_W-1:0]    THRESHOLD_RESET = 10'd32;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } pixel_t;

    localparam int PIX_W = $bits(pixel_t);

    typedef struct packed {
        logic [EW-1:0]       w_eff;
        logic [HEIGHT_W-1:0] h_eff;
    } frame_cfg_t;

    // Item handed from the position sequencer to the window stage
    typedef struct packed {
        logic              valid;
        logic              is_pixel;   // shift window, update line stores
        logic              result;     // produces a result transaction
        logic              from_ram;   // drain result read from newer row store
        logic              eval;       // interior pixel: run neighbour test
        logic              last;
        logic [ADDR_W-1:0] col;
        pixel_t            pix;
    } seq_item_t;

    typedef struct packed {
        logic   result;
        logic   eval;
        logic   last;
        pixel_t pix;
    } stage_t;

    typedef struct packed {
        pixel_t pix;
        logic   kept;
        logic   last;
    } result_t;

    function automatic logic [EW-1:0] eff_width(input logic [WIDTH_W-1:0] w);
        logic [EW-1:0] res;
        if (w < WIDTH_W'(3))
        begin
            res = EW'(3);
        end
        else if (EW'(w) > EW'(MAX_WIDTH))
        begin
            res = EW'(MAX_WIDTH);
        end
        else
        begin
            res = EW'(w);
        end
        return res;
    endfunction

    function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] h);
        logic [HEIGHT_W-1:0] res;
        res = (h < HEIGHT_W'(3)) ? HEIGHT_W'(3) : h;
        return res;
    endfunction

    // Squared RGB distance between two pixels
    function automatic logic [SUM_W-1:0] sq_dist(input pixel_t a, input pixel_t c);
        logic [CH_W-1:0]   dr;
        logic [CH_W-1:0]   dg;
        logic [CH_W-1:0]   db;
        logic [2*CH_W-1:0] sr;
        logic [2*CH_W-1:0] sg;
        logic [2*CH_W-1:0] sb;
        dr = (a.r > c.r) ? (a.r - c.r) : (c.r - a.r);
        dg = (a.g > c.g) ? (a.g - c.g) : (c.g - a.g);
        db = (a.b > c.b) ? (a.b - c.b) : (c.b - a.b);
        sr = (2*CH_W)'(dr) * (2*CH_W)'(dr);
        sg = (2*CH_W)'(dg) * (2*CH_W)'(dg);
        sb = (2*CH_W)'(db) * (2*CH_W)'(db);
        return SUM_W'(sr) + SUM_W'(sg) + SUM_W'(sb);
    endfunction

endpackage

/* rtl/neighbour_count_edge_detect_3x3.sv */
`timescale 1ns / 1ps

// Colour-distance edge detector over a 3x3 window. Feed 24-bit RGB pixels
// in raster order, one per clock when in_stall is low; each interior pixel is
// kept when at least three of its eight neighbours lie at squared RGB
// distance of at least distance_threshold squared, otherwise it comes out
// black with kept low. Border pixels pass unchanged. Results trail the input
// by frame_width + 1 pixels; after the last pixel of a frame, send drain
// transactions to push out the remaining frame_width + 1 results, the final
// one flagged by frame_end. Sustained rate is one transaction per clock on
// both sides while neither side stalls; after its releasing transaction is
// accepted, a result passes the sequencer, window and distance registers
// before it is written into the output queue, and can be taken in the cycle
// after that write. The queue holds eight results, and in_stall rises while
// eight results are accepted but not yet taken. The two row stores need no
// clearing pass after reset. Write the size and threshold registers only
// while the block is idle; a size write restarts the frame.
module neighbour_count_edge_detect_3x3 import ned_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Pixel input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [CH_W-1:0]    red_in,
    input  logic [CH_W-1:0]    green_in,
    input  logic [CH_W-1:0]    blue_in,
    input  logic               drain,
    // Result output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CH_W-1:0]    red_out,
    output logic [CH_W-1:0]    green_out,
    output logic [CH_W-1:0]    blue_out,
    output logic               kept,
    output logic               frame_end
);

    // Configuration registers, raw and as used
    logic [WIDTH_W-1:0]  frame_width_reg;
    logic [HEIGHT_W-1:0] frame_height_reg;
    logic [THR_W-1:0]    threshold_reg;
    logic [EW-1:0]       w_eff_reg;
    logic [HEIGHT_W-1:0] h_eff_reg;
    logic [THR_SQ_W-1:0] thr_sq_reg;

    logic                cfg_wr;
    logic [1:0]          reg_index;
    logic                restart;
    frame_cfg_t          cfg;

    pixel_t                    in_pix;
    logic [ADDR_W-1:0]         raddr;
    logic                      take;
    seq_item_t                 item;
    pixel_t                    older_rdata;
    pixel_t                    newer_rdata;
    logic                      store_we;
    logic [ADDR_W-1:0]         store_waddr;
    pixel_t                    older_wdata;
    pixel_t                    newer_wdata;
    stage_t                    s3;
    logic [NBR-1:0][SUM_W-1:0] sums;
    logic                      push;
    result_t                   push_data;
    result_t                   out_data;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_index = paddr[PADDR_W-1:2];

    // A size write drops any frame in progress
    assign restart = cfg_wr &&
                     ((reg_index == REG_FRAME_WIDTH) || (reg_index == REG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
            threshold_reg    <= THRESHOLD_RESET;
            w_eff_reg        <= eff_width(WIDTH_RESET);
            h_eff_reg        <= eff_height(HEIGHT_RESET);
            thr_sq_reg       <= THR_SQ_W'(THRESHOLD_RESET) * THR_SQ_W'(THRESHOLD_RESET);
        end
        else if (cfg_wr)
        begin
            unique case (reg_index)
                REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= pwdata[WIDTH_W-1:0];
                    w_eff_reg       <= eff_width(pwdata[WIDTH_W-1:0]);
                end
                REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= pwdata[HEIGHT_W-1:0];
                    h_eff_reg        <= eff_height(pwdata[HEIGHT_W-1:0]);
                end
                REG_THRESHOLD:
                begin
                    // Compare squared distances, so keep the threshold squared
                    threshold_reg <= pwdata[THR_W-1:0];
                    thr_sq_reg    <= THR_SQ_W'(pwdata[THR_W-1:0]) *
                                     THR_SQ_W'(pwdata[THR_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_reg);
            REG_THRESHOLD:    prdata = PDATA_W'(threshold_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.w_eff = w_eff_reg;
    assign cfg.h_eff = h_eff_reg;

    assign in_pix.r = red_in;
    assign in_pix.g = green_in;
    assign in_pix.b = blue_in;

    // Track raster position and pending results; issue the row store reads
    ned_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .restart  (restart),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_pix   (in_pix),
        .in_drain (drain),
        .raddr    (raddr),
        .take     (take),
        .item     (item)
    );

    // Row two above the incoming pixel
    ned_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_older_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (older_wdata),
        .raddr (raddr),
        .rdata (older_rdata)
    );

    // Row directly above the incoming pixel; also feeds the last-row drain
    ned_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (newer_wdata),
        .raddr (raddr),
        .rdata (newer_rdata)
    );

    // Advance the window and register the eight neighbour distances
    ned_win u_win (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .older_rdata (older_rdata),
        .newer_rdata (newer_rdata),
        .store_we    (store_we),
        .store_waddr (store_waddr),
        .older_wdata (older_wdata),
        .newer_wdata (newer_wdata),
        .s3          (s3),
        .sums        (sums)
    );

    // Count differing neighbours and black out flat pixels
    ned_vote u_vote (
        .s3        (s3),
        .sums      (sums),
        .thr_sq    (thr_sq_reg),
        .push      (push),
        .push_data (push_data)
    );

    // Queue results so the input keeps flowing while the output stalls
    ned_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .push      (push),
        .push_data (push_data),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_stall (out_stall),
        .in_stall  (in_stall)
    );

    assign red_out   = out_data.pix.r;
    assign green_out = out_data.pix.g;
    assign blue_out  = out_data.pix.b;
    assign kept      = out_data.kept;
    assign frame_end = out_data.last;

endmodule

/* rtl/ned_ram.sv */
`timescale 1ns / 1ps

module ned_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/ned_seq.sv */
`timescale 1ns / 1ps

module ned_seq import ned_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  frame_cfg_t        cfg,
    input  logic              restart,
    input  logic              in_valid,
    input  logic              in_stall,
    input  pixel_t            in_pix,
    input  logic              in_drain,
    output logic [ADDR_W-1:0] raddr,
    output logic              take,
    output seq_item_t         item
);

    logic [ADDR_W-1:0]   col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [EW-1:0]       pend_reg, pend_next;
    seq_item_t           item_reg, item_next;

    logic                accept;
    logic                frame_over;
    logic [ADDR_W-1:0]   x;
    logic [HEIGHT_W-1:0] y;
    logic [EW-1:0]       pend;
    logic [EW-1:0]       w_plus1;
    logic                emit;
    logic [EW-1:0]       col_inc;
    logic                drain_ok;
    logic                drain_full;
    logic [EW-1:0]       pend_d;
    logic [EW-1:0]       drain_addr;

    assign accept  = in_valid && !in_stall;
    assign w_plus1 = cfg.w_eff + EW'(1);

    always_comb
    begin
        frame_over = (row_reg >= cfg.h_eff) || (EW'(col_reg) >= cfg.w_eff);
        x          = frame_over ? '0 : col_reg;
        y          = frame_over ? '0 : row_reg;
        pend       = frame_over ? '0 : pend_reg;
        emit       = (pend >= w_plus1);
        col_inc    = EW'(x) + EW'(1);

        drain_ok   = (row_reg >= cfg.h_eff) && (pend_reg != '0);
        drain_full = (pend_reg >= w_plus1);
        pend_d     = drain_full ? w_plus1 : pend_reg;
        drain_addr = cfg.w_eff - pend_reg;

        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;

        item_next          = '0;
        item_next.pix      = in_pix;
        item_next.col      = x;
        item_next.is_pixel = !in_drain;

        if (in_drain)
        begin
            raddr = drain_addr[ADDR_W-1:0];
        end
        else
        begin
            raddr = x;
        end

        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            pend_next = '0;
        end
        else if (accept && in_drain)
        begin
            if (drain_ok)
            begin
                item_next.valid    = 1'b1;
                item_next.result   = 1'b1;
                item_next.from_ram = !drain_full;
                item_next.last     = (pend_d == EW'(1));
                pend_next          = pend_d - EW'(1);
                if (pend_d == EW'(1))
                begin
                    col_next = '0;
                    row_next = '0;
                end
            end
        end
        else if (accept)
        begin
            item_next.valid  = 1'b1;
            item_next.result = emit;
            item_next.eval   = emit && (y >= HEIGHT_W'(2)) && (x >= ADDR_W'(2));
            pend_next        = emit ? pend : pend + EW'(1);
            if (col_inc >= cfg.w_eff)
            begin
                col_next = '0;
                row_next = y + HEIGHT_W'(1);
            end
            else
            begin
                col_next = col_inc[ADDR_W-1:0];
                row_next = y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
            item_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
            item_reg <= item_next;
        end
    end

    assign take = item_next.valid && item_next.result;
    assign item = item_reg;

endmodule

/* rtl/ned_win.sv */
`timescale 1ns / 1ps

module ned_win import ned_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  seq_item_t                  item,
    input  pixel_t                     older_rdata,
    input  pixel_t                     newer_rdata,
    output logic                       store_we,
    output logic [ADDR_W-1:0]          store_waddr,
    output pixel_t                     older_wdata,
    output pixel_t                     newer_wdata,
    output stage_t                     s3,
    output logic [NBR-1:0][SUM_W-1:0]  sums
);

    pixel_t                    win_reg  [9];
    pixel_t                    win_next [9];
    stage_t                    s2_reg, s2_next;
    stage_t                    s3_reg;
    logic [NBR-1:0][SUM_W-1:0] sum_reg, sum_next;

    // Shift the 3x3 window left by one column, new column on the right
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            win_next[k] = win_reg[k];
        end
        if (item.valid && item.is_pixel)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r*3]     = win_reg[r*3 + 1];
                win_next[r*3 + 1] = win_reg[r*3 + 2];
            end
            win_next[2] = older_rdata;
            win_next[5] = newer_rdata;
            win_next[8] = item.pix;
        end
    end

    always_comb
    begin
        s2_next        = '0;
        s2_next.result = item.valid && item.result;
        s2_next.eval   = item.eval;
        s2_next.last   = item.last;
        s2_next.pix    = item.from_ram ? newer_rdata : win_reg[5];
    end

    // Neighbour distances against the center of the updated window
    always_comb
    begin
        for (int j = 0; j < NBR; j++)
        begin
            sum_next[j] = sq_dist(win_reg[(j < 4) ? j : j + 1], win_reg[4]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            win_reg[k] <= win_next[k];
        end
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
            s3_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
            s3_reg <= s2_reg;
        end
    end

    assign store_we    = item.valid && item.is_pixel;
    assign store_waddr = item.col;
    assign older_wdata = newer_rdata;
    assign newer_wdata = item.pix;
    assign s3          = s3_reg;
    assign sums        = sum_reg;

endmodule

/* rtl/ned_vote.sv */
`timescale 1ns / 1ps

module ned_vote import ned_pkg::*; (
    input  stage_t                     s3,
    input  logic [NBR-1:0][SUM_W-1:0]  sums,
    input  logic [THR_SQ_W-1:0]        thr_sq,
    output logic                       push,
    output result_t                    push_data
);

    logic [CNT_W-1:0] cnt;
    logic             kept;

    always_comb
    begin
        cnt = '0;
        for (int j = 0; j < NBR; j++)
        begin
            cnt = cnt + CNT_W'(THR_SQ_W'(sums[j]) >= thr_sq);
        end
        kept = !s3.eval || (cnt >= CNT_W'(MIN_COUNT));

        push           = s3.result;
        push_data.pix  = kept ? s3.pix : '0;
        push_data.kept = kept;
        push_data.last = s3.last;
    end

endmodule

/* rtl/ned_ofifo.sv */
`timescale 1ns / 1ps

module ned_ofifo import ned_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  logic    push,
    input  result_t push_data,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_stall,
    output logic    in_stall
);

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CREDIT_W-1:0]  fill_reg, fill_next;
    logic [CREDIT_W-1:0]  credit_reg, credit_next;
    logic                 pop;

    assign pop = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + CREDIT_W'(push) - CREDIT_W'(pop);
        // Hold one slot for every result between acceptance and delivery
        credit_next = credit_reg + CREDIT_W'(take) - CREDIT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

    assign out_valid = (fill_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign in_stall  = (credit_reg >= CREDIT_W'(FIFO_DEPTH));

endmodule
